/* hdl/wav_header_parser_macros.svh */
// ----------------------------------------------------------------------------
// wav_header_parser_macros
// Assertion macros used by the wav_header_parser RTL.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WAVHP_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wav_header_parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WAVHP_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wav_header_parser: next-cycle check failed");

`endif

/* hdl/wavhp_pkg.sv */
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types, codes and tag constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    typedef logic [1:0]  opcode_t;
    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  status_t;
    typedef logic [3:0]  phase_t;
    typedef logic [39:0] pos_t;

    // Opcodes
    localparam opcode_t OP_DATA    = 2'd0;
    localparam opcode_t OP_END     = 2'd1;
    localparam opcode_t OP_RESTART = 2'd2;

    // Result status codes
    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_NO_RIFF     = 3'd1;
    localparam status_t ST_NO_WAVE     = 3'd2;
    localparam status_t ST_NOT_PCM     = 3'd3;
    localparam status_t ST_NOT_16BIT   = 3'd4;
    localparam status_t ST_DATA_EARLY  = 3'd5;
    localparam status_t ST_EARLY_END   = 3'd6;

    // Parse phases
    localparam phase_t PH_RIFF     = 4'd0;
    localparam phase_t PH_RIFFSIZE = 4'd1;
    localparam phase_t PH_WAVE     = 4'd2;
    localparam phase_t PH_CTAG     = 4'd3;
    localparam phase_t PH_SZ_FMT   = 4'd4;
    localparam phase_t PH_SZ_DATA  = 4'd5;
    localparam phase_t PH_SZ_OTHER = 4'd6;
    localparam phase_t PH_FORMAT   = 4'd7;
    localparam phase_t PH_CHANNELS = 4'd8;
    localparam phase_t PH_RATE     = 4'd9;
    localparam phase_t PH_BYTERATE = 4'd10;
    localparam phase_t PH_ALIGN    = 4'd11;
    localparam phase_t PH_BITS     = 4'd12;
    localparam phase_t PH_SKIP     = 4'd13;
    localparam phase_t PH_DONE     = 4'd14;

    // Little-endian tags as they appear after four shifted-in bytes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM       = 16'd1;
    localparam logic [15:0] BITS_16       = 16'd16;
    localparam logic [31:0] FMT_BASE_LEN  = 32'd16;
    localparam pos_t        POS_MAX       = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  byte_idx;
        logic [31:0] shift;
        logic [31:0] chunk_len;
        logic [31:0] skip_left;
        logic        fmt_seen;
        logic [31:0] rate;
        logic [15:0] channels;
        pos_t        pos;
    } parse_state_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] rate_hz;
        logic [15:0] chan_num;
        logic [31:0] body_len;
        pos_t        body_start;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_RIFF,
        byte_idx:  2'd0,
        shift:     32'd0,
        chunk_len: 32'd0,
        skip_left: 32'd0,
        fmt_seen:  1'b0,
        rate:      32'd0,
        channels:  16'd0,
        pos:       40'd0
    };

endpackage

/* hdl/wavhp_step.sv */
// ----------------------------------------------------------------------------
// wavhp_step
// Next-state and result logic of the parser for one input beat.
// ----------------------------------------------------------------------------
module wavhp_step
(
    input  wavhp_pkg::parse_state_t cur,
    input  wavhp_pkg::opcode_t      opcode,
    input  wavhp_pkg::byte_t        data_byte,
    output wavhp_pkg::parse_state_t nxt,
    output logic                    emit,
    output wavhp_pkg::result_t      result
);
    import wavhp_pkg::*;

    logic        need_half;
    logic        last_byte;
    logic [31:0] word;
    logic [15:0] half;
    pos_t        pos_inc;
    logic [31:0] skip_dec;
    logic [31:0] fmt_extra;

    assign word      = {data_byte, cur.shift[31:8]};
    assign half      = word[31:16];
    assign pos_inc   = (cur.pos < POS_MAX) ? cur.pos + 40'd1 : cur.pos;
    assign skip_dec  = cur.skip_left - 32'd1;
    assign fmt_extra = (cur.chunk_len > FMT_BASE_LEN) ? cur.chunk_len - FMT_BASE_LEN : 32'd0;
    assign need_half = (cur.phase == PH_FORMAT) || (cur.phase == PH_CHANNELS) ||
                       (cur.phase == PH_ALIGN)  || (cur.phase == PH_BITS);
    assign last_byte = need_half ? (cur.byte_idx != 2'd0) : (cur.byte_idx == 2'd3);

    always_comb
    begin
        nxt    = cur;
        emit   = 1'b0;
        result = '0;

        if (opcode == OP_RESTART)
        begin
            nxt = STATE_RESET;
        end
        else if (opcode == OP_END)
        begin
            if (cur.phase != PH_DONE)
            begin
                emit          = 1'b1;
                result.status = ST_EARLY_END;
                nxt.phase     = PH_DONE;
            end
        end
        else if (opcode == OP_DATA && cur.phase != PH_DONE)
        begin
            nxt.pos = pos_inc;
            if (cur.phase == PH_SKIP)
            begin
                nxt.skip_left = skip_dec;
                if (skip_dec == 32'd0)
                    nxt.phase = PH_CTAG;
            end
            else if (cur.phase < PH_SKIP)
            begin
                nxt.shift = word;
                if (!last_byte)
                begin
                    nxt.byte_idx = cur.byte_idx + 2'd1;
                end
                else
                begin
                    nxt.byte_idx = 2'd0;
                    case (cur.phase)
                        PH_RIFF:
                        begin
                            if (word != TAG_RIFF)
                            begin
                                emit          = 1'b1;
                                result.status = ST_NO_RIFF;
                                nxt.phase     = PH_DONE;
                            end
                            else
                                nxt.phase = PH_RIFFSIZE;
                        end
                        PH_RIFFSIZE: nxt.phase = PH_WAVE;
                        PH_WAVE:
                        begin
                            if (word != TAG_WAVE)
                            begin
                                emit          = 1'b1;
                                result.status = ST_NO_WAVE;
                                nxt.phase     = PH_DONE;
                            end
                            else
                                nxt.phase = PH_CTAG;
                        end
                        PH_CTAG:
                        begin
                            if (word == TAG_FMT)
                                nxt.phase = PH_SZ_FMT;
                            else if (word == TAG_DATA)
                                nxt.phase = PH_SZ_DATA;
                            else
                                nxt.phase = PH_SZ_OTHER;
                        end
                        PH_SZ_FMT:
                        begin
                            nxt.chunk_len = word;
                            nxt.phase     = PH_FORMAT;
                        end
                        PH_SZ_DATA:
                        begin
                            nxt.chunk_len = word;
                            nxt.phase     = PH_DONE;
                            emit          = 1'b1;
                            if (!cur.fmt_seen)
                                result.status = ST_DATA_EARLY;
                            else
                            begin
                                result.status     = ST_OK;
                                result.rate_hz    = cur.rate;
                                result.chan_num   = cur.channels;
                                result.body_len   = word;
                                result.body_start = pos_inc;
                            end
                        end
                        PH_SZ_OTHER:
                        begin
                            nxt.chunk_len = word;
                            nxt.skip_left = word;
                            nxt.phase     = (word == 32'd0) ? PH_CTAG : PH_SKIP;
                        end
                        PH_FORMAT:
                        begin
                            if (half != FMT_PCM)
                            begin
                                emit          = 1'b1;
                                result.status = ST_NOT_PCM;
                                nxt.phase     = PH_DONE;
                            end
                            else
                                nxt.phase = PH_CHANNELS;
                        end
                        PH_CHANNELS:
                        begin
                            nxt.channels = half;
                            nxt.phase    = PH_RATE;
                        end
                        PH_RATE:
                        begin
                            nxt.rate  = word;
                            nxt.phase = PH_BYTERATE;
                        end
                        PH_BYTERATE: nxt.phase = PH_ALIGN;
                        PH_ALIGN:    nxt.phase = PH_BITS;
                        PH_BITS:
                        begin
                            if (half != BITS_16)
                            begin
                                emit          = 1'b1;
                                result.status = ST_NOT_16BIT;
                                nxt.phase     = PH_DONE;
                            end
                            else
                            begin
                                nxt.fmt_seen  = 1'b1;
                                nxt.skip_left = fmt_extra;
                                nxt.phase     = (fmt_extra == 32'd0) ? PH_CTAG : PH_SKIP;
                            end
                        end
                        default: nxt = cur;
                    endcase
                end
            end
        end
    end

endmodule

/* hdl/wav_header_parser.sv */
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-serial RIFF/WAVE header parser with valid/ready channels.
// ----------------------------------------------------------------------------
// The parser takes one beat per clock cycle while in_ready is high, each beat
// carrying an opcode (data byte, end of stream or restart) and a file byte. A
// beat passes through an input stage register, then a single pass of parse logic
// updates the parser state and, when a report is due, loads the result register.
// At most one report is produced per parse: the success report when the data
// chunk header has been read, or an error report; a restart before either
// produces none. After a report every beat but a restart is consumed silently.
// The input side keeps accepting beats while a report waits on the output, and
// only stalls when a second report is due before the first one has been taken.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module wav_header_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wavhp_pkg::opcode_t   opcode,
    input  wavhp_pkg::byte_t     data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wavhp_pkg::status_t   status,
    output logic [31:0]          rate_hz,
    output logic [15:0]          chan_num,
    output logic [31:0]          body_len,
    output wavhp_pkg::pos_t      body_start
);
    import wavhp_pkg::*;
    `include "wav_header_parser_macros.svh"

    // Input stage: one beat waiting for the parse logic.
    logic         stage_valid_reg;
    logic         stage_valid_next;
    opcode_t      stage_op_reg;
    byte_t        stage_byte_reg;

    // Parser state, updated whenever the staged beat advances.
    parse_state_t state_reg;
    parse_state_t state_next;

    // Result register feeding the output channel.
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      result_reg;

    logic         step_emit;
    result_t      step_result;
    logic         stage_adv;
    logic         out_load;
    logic         in_accept;

    wavhp_step u_step
    (
        .cur       (state_reg),
        .opcode    (stage_op_reg),
        .data_byte (stage_byte_reg),
        .nxt       (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    // A staged beat that produces no report can always advance. One that
    // produces a report needs the result register free or being drained.
    assign stage_adv = stage_valid_reg && (!step_emit || !out_valid_reg || out_ready);
    assign out_load  = stage_adv && step_emit;
    assign in_ready  = !stage_valid_reg || stage_adv;
    assign in_accept = in_valid && in_ready;

    assign stage_valid_next = in_accept ? 1'b1 : (stage_adv ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= STATE_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (stage_adv)
                state_reg <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_op_reg   <= opcode;
            stage_byte_reg <= data_byte;
        end
        if (out_load)
            result_reg <= step_result;
    end

    assign out_valid  = out_valid_reg;
    assign status     = result_reg.status;
    assign rate_hz    = result_reg.rate_hz;
    assign chan_num   = result_reg.chan_num;
    assign body_len   = result_reg.body_len;
    assign body_start = result_reg.body_start;

    // Every report leaves the parser in its finished phase.
    `WAVHP_ASSERT_NEXT(a_report_finishes, out_load, state_reg.phase == PH_DONE)
    // A success report is only possible once a valid fmt chunk was parsed.
    `WAVHP_ASSERT_IMPL(a_ok_needs_fmt, out_load && step_result.status == ST_OK,
                       state_reg.fmt_seen)
    // A staged beat that cannot advance is held intact.
    `WAVHP_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !stage_adv,
                       stage_valid_reg && $stable(stage_op_reg) && $stable(stage_byte_reg))
    // The input only stalls when both the stage and the result register are full.
    `WAVHP_ASSERT_IMPL(a_stall_cause, !in_ready, stage_valid_reg && out_valid_reg)

endmodule

/* sim/wav_header_parser_tb.sv */
// ----------------------------------------------------------------------------
// wav_header_parser_tb
// Self-checking testbench for the byte-serial RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
// Byte streams are built as whole files: tags, chunk sizes, fmt fields and
// skipped bodies, with random content and a share of corrupt, truncated and
// garbage files. Every accepted input beat is fed to a cycle-free model of the
// parser, which queues the report that the beat should cause. Each report
// taken from the block is compared field by field with the oldest queued one.
// The sender idles in random bursts and the receiver stalls on its own
// pattern, so that reports meet back-pressure in every parse phase.
// ----------------------------------------------------------------------------
module wav_header_parser_tb;
    import wavhp_pkg::*;

    // The fourth opcode value has no meaning and must be ignored.
    localparam opcode_t OP_SPARE = 2'd3;

    // Scoreboard: tracks the parser state and holds the reports still owed.
    class header_report_board;
        phase_t      stage;
        logic [1:0]  field_idx;
        logic [31:0] assembled;
        logic [31:0] chunk_len;
        logic [31:0] skip_left;
        bit          fmt_done;
        logic [31:0] rate;
        logic [15:0] channels;
        pos_t        consumed;
        result_t     owed_reports[$];
        int          mismatches;

        function new();
            restart_parse();
            mismatches = 0;
        endfunction

        function void restart_parse();
            stage     = PH_RIFF;
            field_idx = '0;
            assembled = '0;
            chunk_len = '0;
            skip_left = '0;
            fmt_done  = 1'b0;
            rate      = '0;
            channels  = '0;
            consumed  = '0;
        endfunction

        function void post_report(result_t r);
            owed_reports.push_back(r);
            stage = PH_DONE;
        endfunction

        function void post_error(status_t code);
            result_t r;
            r = '0;
            r.status = code;
            post_report(r);
        endfunction

        function void begin_skip(logic [31:0] count);
            skip_left = count;
            stage = (count == 0) ? PH_CTAG : PH_SKIP;
        endfunction

        // Returns 1 when the beat does anything at all to the parser.
        function bit note_input(opcode_t op, byte_t b);
            int          need;
            logic [31:0] word;
            logic [15:0] half;
            result_t     ok;
            if (op == OP_RESTART)
            begin
                restart_parse();
                return 1'b1;
            end
            if (op == OP_SPARE || stage == PH_DONE)
                return 1'b0;
            if (op == OP_END)
            begin
                post_error(ST_EARLY_END);
                return 1'b1;
            end
            if (consumed != POS_MAX)
                consumed = consumed + 40'd1;
            if (stage == PH_SKIP)
            begin
                skip_left = skip_left - 1;
                if (skip_left == 0)
                    stage = PH_CTAG;
                return 1'b1;
            end
            assembled = {b, assembled[31:8]};
            case (stage)
                PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: need = 2;
                default: need = 4;
            endcase
            if (int'(field_idx) + 1 < need)
            begin
                field_idx = field_idx + 2'd1;
                return 1'b1;
            end
            field_idx = '0;
            word = assembled;
            half = assembled[31:16];
            case (stage)
                PH_RIFF:
                    if (word != TAG_RIFF) post_error(ST_NO_RIFF);
                    else stage = PH_RIFFSIZE;
                PH_RIFFSIZE:
                    stage = PH_WAVE;
                PH_WAVE:
                    if (word != TAG_WAVE) post_error(ST_NO_WAVE);
                    else stage = PH_CTAG;
                PH_CTAG:
                    stage = (word == TAG_FMT)  ? PH_SZ_FMT :
                            (word == TAG_DATA) ? PH_SZ_DATA : PH_SZ_OTHER;
                PH_SZ_FMT:
                begin
                    chunk_len = word;
                    stage = PH_FORMAT;
                end
                PH_SZ_DATA:
                begin
                    chunk_len = word;
                    if (!fmt_done)
                        post_error(ST_DATA_EARLY);
                    else
                    begin
                        ok.status     = ST_OK;
                        ok.rate_hz    = rate;
                        ok.chan_num   = channels;
                        ok.body_len   = word;
                        ok.body_start = consumed;
                        post_report(ok);
                    end
                end
                PH_SZ_OTHER:
                begin
                    chunk_len = word;
                    begin_skip(word);
                end
                PH_FORMAT:
                    if (half != FMT_PCM) post_error(ST_NOT_PCM);
                    else stage = PH_CHANNELS;
                PH_CHANNELS:
                begin
                    channels = half;
                    stage = PH_RATE;
                end
                PH_RATE:
                begin
                    rate = word;
                    stage = PH_BYTERATE;
                end
                PH_BYTERATE:
                    stage = PH_ALIGN;
                PH_ALIGN:
                    stage = PH_BITS;
                default:
                    if (half != BITS_16)
                        post_error(ST_NOT_16BIT);
                    else
                    begin
                        // A short fmt chunk skips nothing beyond its 16 bytes.
                        fmt_done = 1'b1;
                        begin_skip(chunk_len > FMT_BASE_LEN ? chunk_len - FMT_BASE_LEN : '0);
                    end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [39:0] want, logic [39:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_reports.size() == 0)
            begin
                $error("report with status %0d arrived with none owed", got.status);
                mismatches++;
                return;
            end
            want = owed_reports.pop_front();
            compare_field("status", 40'(want.status), 40'(got.status));
            compare_field("rate_hz", 40'(want.rate_hz), 40'(got.rate_hz));
            compare_field("chan_num", 40'(want.chan_num), 40'(got.chan_num));
            compare_field("body_len", 40'(want.body_len), 40'(got.body_len));
            compare_field("body_start", want.body_start, got.body_start);
        endfunction
    endclass

    typedef struct packed {
        opcode_t code;
        byte_t   value;
    } beat_t;

    // All inputs start at known values; reset is held low from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    opcode_t     opcode    = OP_DATA;
    byte_t       data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    status_t     status;
    logic [31:0] rate_hz;
    logic [15:0] chan_num;
    logic [31:0] body_len;
    pos_t        body_start;

    header_report_board board;
    beat_t              script[$];
    int unsigned        burst_left = 0;
    int unsigned        live_beats = 0;
    bit                 steady     = 1'b0;

    wav_header_parser dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .rate_hz    (rate_hz),
        .chan_num   (chan_num),
        .body_len   (body_len),
        .body_start (body_start)
    );

    always #5 clk = ~clk;

    // Outputs are sampled right after the edge, before any register update
    // of that edge lands, so the values seen are the ones the edge captured.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({status, rate_hz, chan_num, body_len, body_start});
    end

    // Receiver back-pressure: the mode is redrawn periodically from always
    // ready, coin flips, rare ready cycles and a fixed duty pattern.
    initial
    begin : receiver
        int unsigned tick;
        int unsigned mode;
        tick = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 200 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= ((tick % 16) < 5);
            endcase
        end
    end

    // Hard stop in case a report never shows up or the input hangs.
    initial
    begin
        #2_000_000;
        $display("[wav_header_parser] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Beat driving. Every call starts in the time step of a rising edge.
    // valid is only lowered for a gap or in wait_for_reports, and an edge
    // follows before it rises, so valid never sees two updates in one step.
    // ------------------------------------------------------------------
    task automatic push_beat(opcode_t op, byte_t b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if (steady)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 30);
            else
                gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        void'(board.note_input(op, b));
        live_beats++;
    endtask

    // Holds the input idle until every owed report has been taken.
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_reports.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Plays the built file, now and then slipping in a beat with the spare opcode.
    task automatic play_script();
        foreach (script[i])
        begin
            if ($urandom_range(0, 49) == 0)
                push_beat(OP_SPARE, 8'($urandom));
            push_beat(script[i].code, script[i].value);
        end
    endtask

    // ------------------------------------------------------------------
    // File building.
    // ------------------------------------------------------------------
    function automatic void add_beat(opcode_t op, byte_t b);
        beat_t bt;
        bt.code  = op;
        bt.value = b;
        script.push_back(bt);
    endfunction

    function automatic void add_byte(byte_t b);
        add_beat(OP_DATA, b);
    endfunction

    function automatic void add_half(logic [15:0] h);
        add_byte(h[7:0]);
        add_byte(h[15:8]);
    endfunction

    function automatic void add_word(logic [31:0] w);
        add_half(w[15:0]);
        add_half(w[31:16]);
    endfunction

    // A tag that is corrupted in one bit a few percent of the time.
    function automatic void add_tag(logic [31:0] tag);
        if ($urandom_range(0, 99) < 5)
            add_word(tag ^ (32'd1 << $urandom_range(0, 31)));
        else
            add_word(tag);
    endfunction

    // Unknown chunk: the top tag byte is at least 0x80, so it can never be
    // taken for a fmt or data tag. Bodies are kept short.
    function automatic void add_other_chunk();
        int unsigned len;
        len = $urandom_range(0, 6);
        add_word({1'b1, 31'($urandom)});
        add_word(len);
        repeat (len) add_byte(8'($urandom));
    endfunction

    // fmt chunk with a mostly valid body. A huge length is only used where
    // the stream is cut off with an end of stream inside the skipped tail.
    function automatic void add_fmt_chunk(bit huge);
        logic [31:0] len;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (huge)
            len = 32'hFFFF_FFFF - $urandom_range(0, 15);
        else if (pick < 50)
            len = FMT_BASE_LEN;
        else if (pick < 65)
            len = $urandom_range(0, 15);
        else
            len = FMT_BASE_LEN + $urandom_range(1, 6);
        add_word(TAG_FMT);
        add_word(len);
        add_half(($urandom_range(0, 99) < 8) ? 16'($urandom) : FMT_PCM);
        add_half(16'($urandom));
        add_word($urandom);
        add_word($urandom);
        add_half(16'($urandom));
        add_half(($urandom_range(0, 99) < 8) ? 16'($urandom) : BITS_16);
        if (!huge && len > FMT_BASE_LEN)
            repeat (len - FMT_BASE_LEN) add_byte(8'($urandom));
    endfunction

    // Builds one file into the script, always closed by a restart.
    function automatic void compose_file();
        int unsigned kind;
        int unsigned cut;
        logic [31:0] size;
        script.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // Garbage with random opcodes; it can fail the RIFF check.
            repeat ($urandom_range(1, 12))
                add_beat(opcode_t'($urandom_range(0, 3)), 8'($urandom));
            add_beat(OP_RESTART, 8'($urandom));
            return;
        end
        add_tag(TAG_RIFF);
        add_word($urandom);
        add_tag(TAG_WAVE);
        if (kind < 16)
        begin
            // End of stream in the middle of a very long skipped region.
            if ($urandom_range(0, 1))
            begin
                add_word({1'b1, 31'($urandom)});
                add_word(32'hFFFF_FFF0 | $urandom_range(0, 15));
            end
            else
                add_fmt_chunk(1'b1);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
            add_beat(OP_END, 8'($urandom));
            add_beat(OP_RESTART, 8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2)) add_other_chunk();
        if (kind >= 22)
        begin
            add_fmt_chunk(1'b0);
            if ($urandom_range(0, 4) == 0)
                add_other_chunk();
            // A second fmt chunk overwrites the rate and channel count.
            if ($urandom_range(0, 5) == 0)
                add_fmt_chunk(1'b0);
        end
        case ($urandom_range(0, 5))
            0: size = '0;
            1: size = '1;
            default: size = $urandom;
        endcase
        add_word(TAG_DATA);
        add_word(size);
        cut = $urandom_range(0, 99);
        if (cut < 24)
        begin
            // Truncated file: with an end of stream, or just a restart.
            cut = $urandom_range(0, script.size() - 1);
            while (script.size() > cut)
                void'(script.pop_back());
            if ($urandom_range(0, 3) != 0)
                add_beat(OP_END, 8'($urandom));
        end
        else
        begin
            // Bytes and an end after the report must all be ignored.
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            if ($urandom_range(0, 1))
                add_beat(OP_END, 8'($urandom));
        end
        add_beat(OP_RESTART, 8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned files;
        files = 0;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: early end straight after reset, an end and a byte after a
        // report, the spare opcode at both byte extremes, a bad RIFF tag with
        // a zero byte, and a bad WAVE tag behind an all-ones RIFF size.
        script.delete();
        add_beat(OP_END, 8'hFF);
        add_beat(OP_END, 8'h00);
        add_byte(8'h52);
        add_beat(OP_RESTART, 8'hFF);
        add_beat(OP_SPARE, 8'hFF);
        add_beat(OP_SPARE, 8'h00);
        add_word({8'h00, TAG_RIFF[23:0]});
        add_beat(OP_RESTART, 8'h00);
        add_word(TAG_RIFF);
        add_word(32'hFFFF_FFFF);
        add_word(TAG_WAVE ^ 32'd1);
        add_beat(OP_RESTART, 8'h00);
        steady = 1'b1;
        play_script();

        // Let everything drain once before the random files start.
        wait_for_reports();

        while (live_beats < 1350)
        begin
            steady = ($urandom_range(0, 4) == 0);
            compose_file();
            play_script();
            files++;
            if (files % 7 == 0)
                wait_for_reports();
        end

        wait_for_reports();
        // Leave the clock running so that anything spurious can still show up.
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.owed_reports.size() == 0)
            $display("[wav_header_parser] OK");
        else
            $display("[wav_header_parser] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/wavhp_pkg.sv
hdl/wavhp_step.sv
hdl/wav_header_parser.sv
sim/wav_header_parser_tb.sv
